### rtl/core/assert_macros.svh
// assertion macros shared by the selector rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/efps_pkg.sv
// shared types and constants for the earliest finish pe selector
`timescale 1ns / 1ps
`default_nettype none

package efps_pkg;

   localparam int EST_W      = 48;
   localparam int EXEC_W     = 32;
   localparam int MASK_W     = 8;
   localparam int OUT_IDX_W  = 3;
   localparam int TYPE_W     = 2;
   localparam int NUM_EXEC   = 4;
   localparam int NUM_CFG_W  = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ELEMENTS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEMENT_TYPES = 2'd1;

   localparam logic [NUM_CFG_W-1:0]  NUM_ELEMENTS_RESET  = 4'd8;
   localparam logic [CSR_DATA_W-1:0] ELEMENT_TYPES_RESET = 16'd0;

   localparam logic KIND_PLACE = 1'b0;
   localparam logic KIND_RAISE = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic step;
      logic commit;
   } efps_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic fast_path;
      logic scan_last;
   } efps_sts_type;

endpackage

`default_nettype wire

### rtl/core/efps_ctrl.sv
// controller sequencing accept, element scan and result commit
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module efps_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   input  efps_pkg::efps_sts_type sts,
   output efps_pkg::efps_cmd_type cmd
);
   import efps_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      cmd.start  = 1'b0;
      cmd.step   = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = sts.fast_path ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ASSERT_NEXT(a_accept_blocks, clock, reset, req_valid && req_ready, !req_ready,
                "input taken while a transaction is in flight")
   `ASSERT_NEXT(a_commit_valid, clock, reset, cmd.commit, rsp_valid,
                "committed result not presented")
   `ASSERT_CLK(a_commit_slot, clock, reset, !cmd.commit || !rsp_valid_ff || rsp_ready,
               "result register overwritten while stalled")

endmodule

`default_nettype wire

### rtl/core/efps_datapath.sv
// ready time store, per element finish compare and result registers
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module efps_datapath #(
   parameter int NUM_ELEMENTS = 8,
   parameter int NUM_TYPES    = 4,
   parameter int TIME_BITS    = 48
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_valid,
   input  wire  [efps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [efps_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire                                  req_kind,
   input  wire  [efps_pkg::EST_W-1:0]           req_earliest_start,
   input  wire  [efps_pkg::MASK_W-1:0]          req_allowed_mask,
   input  wire                                  req_already_running,
   input  wire  [efps_pkg::EXEC_W-1:0]          req_exec_time_type0,
   input  wire  [efps_pkg::EXEC_W-1:0]          req_exec_time_type1,
   input  wire  [efps_pkg::EXEC_W-1:0]          req_exec_time_type2,
   input  wire  [efps_pkg::EXEC_W-1:0]          req_exec_time_type3,
   output logic [efps_pkg::OUT_IDX_W-1:0]       rsp_chosen_element,
   output logic                                 rsp_found,
   output logic [efps_pkg::EST_W-1:0]           rsp_start_time,
   output logic [efps_pkg::EST_W-1:0]           rsp_end_time,
   input  efps_pkg::efps_cmd_type               cmd,
   output efps_pkg::efps_sts_type               sts
);
   import efps_pkg::*;

   localparam int CNT_W = $clog2(NUM_ELEMENTS + 1);
   localparam int IDX_W = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
   localparam int SUM_W = ((TIME_BITS > EXEC_W) ? TIME_BITS : EXEC_W) + 1;
   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

   logic [NUM_CFG_W-1:0]  num_elements_ff;
   logic [CSR_DATA_W-1:0] element_types_ff;

   logic [TIME_BITS-1:0]  ready_time_ff [NUM_ELEMENTS];
   logic [TIME_BITS-1:0]  ready_time_in [NUM_ELEMENTS];

   logic                  kind_ff, running_ff;
   logic [TIME_BITS-1:0]  est_ff;
   logic [MASK_W-1:0]     mask_ff;
   logic [EXEC_W-1:0]     exec_ff [NUM_EXEC];

   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  have_ff, have_in;
   logic [IDX_W-1:0]      best_idx_ff;
   logic [TIME_BITS-1:0]  best_start_ff, best_end_ff, best_wait_ff;

   logic [CNT_W-1:0]      count;
   logic [IDX_W-1:0]      pe_idx;
   logic [OUT_IDX_W-1:0]  pe3;
   logic [TYPE_W-1:0]     pe_type;
   logic                  candidate, better, found_w;
   logic [TIME_BITS-1:0]  cur_ready, cur_start, cur_wait, cur_end;
   logic [SUM_W-1:0]      cur_sum;

   // config registers, to be written only while idle; the block itself does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         num_elements_ff  <= NUM_ELEMENTS_RESET;
         element_types_ff <= ELEMENT_TYPES_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_NUM_ELEMENTS:  num_elements_ff  <= csr_wdata[NUM_CFG_W-1:0];
            CSR_ELEMENT_TYPES: element_types_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // elements in use, clamped to the built count
   assign count = ({1'b0, num_elements_ff} > (NUM_CFG_W+1)'(NUM_ELEMENTS)) ?
                  CNT_W'(NUM_ELEMENTS) : CNT_W'(num_elements_ff);

   assign sts.fast_path = (req_kind == KIND_RAISE) || req_already_running ||
                          (count == '0);
   assign sts.scan_last = (CNT_W'(cnt_ff + 1'b1) == count);

   // one element per scan cycle
   assign pe_idx    = cnt_ff[IDX_W-1:0];
   assign pe3       = OUT_IDX_W'(cnt_ff);
   assign pe_type   = (cnt_ff < CNT_W'(MASK_W)) ? element_types_ff[{pe3, 1'b0} +: TYPE_W]
                                                 : '0;
   assign candidate = (cnt_ff < CNT_W'(MASK_W)) && mask_ff[pe3] &&
                      (int'(pe_type) < NUM_TYPES);

   assign cur_ready = ready_time_ff[pe_idx];
   assign cur_start = (cur_ready > est_ff) ? cur_ready : est_ff;
   assign cur_wait  = cur_start - cur_ready;
   assign cur_sum   = SUM_W'(cur_start) + SUM_W'(exec_ff[pe_type]);
   assign cur_end   = (cur_sum > SUM_W'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(cur_sum);

   assign better = !have_ff || (cur_end < best_end_ff) ||
                   ((cur_end == best_end_ff) && (cur_wait < best_wait_ff));

   assign found_w = have_ff && (kind_ff == KIND_PLACE) && !running_ff;

   always_comb begin
      cnt_in  = cnt_ff;
      have_in = have_ff;
      if (cmd.start) begin
         cnt_in  = '0;
         have_in = 1'b0;
      end else if (cmd.step) begin
         if (candidate) begin
            have_in = have_ff | better;
         end
         if (!sts.scan_last) begin
            cnt_in = CNT_W'(cnt_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         have_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         have_ff <= have_in;
      end
   end

   // captured transaction and running best
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         kind_ff    <= req_kind;
         running_ff <= req_already_running;
         est_ff     <= TIME_BITS'(req_earliest_start);
         mask_ff    <= req_allowed_mask;
         exec_ff[0] <= req_exec_time_type0;
         exec_ff[1] <= req_exec_time_type1;
         exec_ff[2] <= req_exec_time_type2;
         exec_ff[3] <= req_exec_time_type3;
      end
      if (cmd.step && candidate && better) begin
         best_idx_ff   <= pe_idx;
         best_start_ff <= cur_start;
         best_end_ff   <= cur_end;
         best_wait_ff  <= cur_wait;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_ELEMENTS; i++) begin
         ready_time_in[i] = ready_time_ff[i];
         if (cmd.commit) begin
            if (kind_ff == KIND_RAISE) begin
               if (ready_time_ff[i] < est_ff) begin
                  ready_time_in[i] = est_ff;
               end
            end else if (found_w && (best_idx_ff == IDX_W'(i))) begin
               ready_time_in[i] = best_end_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ELEMENTS; i++) begin
            ready_time_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < NUM_ELEMENTS; i++) begin
            ready_time_ff[i] <= ready_time_in[i];
         end
      end
   end

   // output register, loaded once per transaction
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (kind_ff == KIND_RAISE) begin
            rsp_chosen_element <= '0;
            rsp_found          <= 1'b0;
            rsp_start_time     <= '0;
            rsp_end_time       <= '0;
         end else if (running_ff) begin
            rsp_chosen_element <= '0;
            rsp_found          <= 1'b0;
            rsp_start_time     <= EST_W'(est_ff);
            rsp_end_time       <= EST_W'(est_ff);
         end else if (found_w) begin
            rsp_chosen_element <= OUT_IDX_W'(best_idx_ff);
            rsp_found          <= 1'b1;
            rsp_start_time     <= EST_W'(best_start_ff);
            rsp_end_time       <= EST_W'(best_end_ff);
         end else begin
            rsp_chosen_element <= '0;
            rsp_found          <= 1'b0;
            rsp_start_time     <= '0;
            rsp_end_time       <= '0;
         end
      end
   end

   `ASSERT_NEXT(a_writeback, clock, reset, cmd.commit && found_w,
                ready_time_ff[$past(best_idx_ff)] == $past(best_end_ff),
                "chosen element ready time not moved to its end time")
   `ASSERT_NEXT(a_raise_floor, clock, reset, cmd.commit && (kind_ff == KIND_RAISE),
                ready_time_ff[0] >= $past(est_ff),
                "ready time below floor after raise")
   `ASSERT_CLK(a_step_range, clock, reset, !cmd.step || (cnt_ff < count),
               "scan index beyond elements in use")

endmodule

`default_nettype wire

### rtl/core/earliest_finish_pe_selector.sv
// Earliest finish time processing element selector, top level.
//
// Input channel req_*: one transaction per task (kind 0) or ready time raise
// (kind 1). Result channel rsp_*: exactly one transaction per input, in order.
// Config channel csr_*: index 0 sets the element count, index 1 the two bit
// element types; always ready, write only while no transaction is in flight.
//
// A task is scanned one element per cycle through a single add and compare
// unit against the stored ready times, then the result is committed to the
// output register and the block returns to accept the next input. Raise
// items, already running tasks and a zero element count skip the scan.
// The result sits in an output register: the next input is accepted while it
// waits. If the receiver stalls, the following transaction finishes its scan
// and holds until the register frees up.
// Reset clears every ready time to zero, sets the element count to 8 and all
// element types to 0.
`timescale 1ns / 1ps
`default_nettype none

module earliest_finish_pe_selector #(
   parameter int NUM_ELEMENTS = 8,
   parameter int NUM_TYPES    = 4,
   parameter int TIME_BITS    = 48
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [efps_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [efps_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire                              req_kind,
   input  wire  [efps_pkg::EST_W-1:0]       req_earliest_start,
   input  wire  [efps_pkg::MASK_W-1:0]      req_allowed_mask,
   input  wire                              req_already_running,
   input  wire  [efps_pkg::EXEC_W-1:0]      req_exec_time_type0,
   input  wire  [efps_pkg::EXEC_W-1:0]      req_exec_time_type1,
   input  wire  [efps_pkg::EXEC_W-1:0]      req_exec_time_type2,
   input  wire  [efps_pkg::EXEC_W-1:0]      req_exec_time_type3,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [efps_pkg::OUT_IDX_W-1:0]   rsp_chosen_element,
   output logic                             rsp_found,
   output logic [efps_pkg::EST_W-1:0]       rsp_start_time,
   output logic [efps_pkg::EST_W-1:0]       rsp_end_time
);
   import efps_pkg::*;

   efps_cmd_type cmd;
   efps_sts_type sts;

   assign csr_ready = 1'b1;

   efps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   efps_datapath #(
      .NUM_ELEMENTS (NUM_ELEMENTS),
      .NUM_TYPES    (NUM_TYPES),
      .TIME_BITS    (TIME_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_kind            (req_kind),
      .req_earliest_start  (req_earliest_start),
      .req_allowed_mask    (req_allowed_mask),
      .req_already_running (req_already_running),
      .req_exec_time_type0 (req_exec_time_type0),
      .req_exec_time_type1 (req_exec_time_type1),
      .req_exec_time_type2 (req_exec_time_type2),
      .req_exec_time_type3 (req_exec_time_type3),
      .rsp_chosen_element  (rsp_chosen_element),
      .rsp_found           (rsp_found),
      .rsp_start_time      (rsp_start_time),
      .rsp_end_time        (rsp_end_time),
      .cmd                 (cmd),
      .sts                 (sts)
   );

endmodule

`default_nettype wire
